// File: hdl/ftr_pkg.sv
`default_nettype none

package ftr_pkg;

    localparam int STAMP_W  = 48;
    localparam int PROTO_W  = 64;
    localparam int PERIOD_W = 10;
    localparam int COUNT_W  = 10;
    localparam int LIMIT_W  = 16;
    localparam int DEBT_W   = STAMP_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    // Reset values of the configuration registers.
    localparam logic [PERIOD_W-1:0] DEFAULT_PERIOD_RST = 10'd40;
    localparam logic [COUNT_W-1:0]  WARMUP_FRAMES_RST  = 10'd200;
    localparam logic [LIMIT_W-1:0]  MAX_RETREAT_RST    = 16'd100;
    localparam logic [LIMIT_W-1:0]  RESET_JUMP_RST     = 16'd1000;
    localparam logic [LIMIT_W-1:0]  MAX_JUMP_RST       = 16'd5000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEFAULT_PERIOD = 3'd0,
        REG_WARMUP_FRAMES  = 3'd1,
        REG_MAX_RETREAT    = 3'd2,
        REG_RESET_JUMP     = 3'd3,
        REG_MAX_JUMP       = 3'd4,
        REG_BASE_VALID     = 3'd5,
        REG_BASE_STAMP     = 3'd6
    } cfg_reg_e;

    typedef struct packed {
        logic [PERIOD_W-1:0] default_period;
        logic [COUNT_W-1:0]  warmup_frames;
        logic [LIMIT_W-1:0]  max_retreat;
        logic [LIMIT_W-1:0]  reset_jump;
        logic [LIMIT_W-1:0]  max_jump;
        logic                base_valid;
        logic [STAMP_W-1:0]  base_stamp;
    } cfg_t;

    typedef struct packed {
        logic signed [PROTO_W-1:0] proto_stamp;
        logic [STAMP_W-1:0]        wall_time;
        logic [PERIOD_W-1:0]       estimated_period;
    } in_item_t;

    typedef struct packed {
        logic [STAMP_W-1:0] out_stamp;
        logic               error;
    } out_item_t;

endpackage

`default_nettype wire

// File: hdl/ftr_cfg.sv
`default_nettype none

module ftr_cfg (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [ftr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ftr_pkg::CFG_DATA_W-1:0] cfg_data,
    output ftr_pkg::cfg_t                       cfg
);
    import ftr_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.default_period <= DEFAULT_PERIOD_RST;
            cfg_reg.warmup_frames  <= WARMUP_FRAMES_RST;
            cfg_reg.max_retreat    <= MAX_RETREAT_RST;
            cfg_reg.reset_jump     <= RESET_JUMP_RST;
            cfg_reg.max_jump       <= MAX_JUMP_RST;
            cfg_reg.base_valid     <= 1'b0;
            cfg_reg.base_stamp     <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_e'(cfg_index))
                REG_DEFAULT_PERIOD: cfg_reg.default_period <= cfg_data[PERIOD_W-1:0];
                REG_WARMUP_FRAMES:  cfg_reg.warmup_frames  <= cfg_data[COUNT_W-1:0];
                REG_MAX_RETREAT:    cfg_reg.max_retreat    <= cfg_data[LIMIT_W-1:0];
                REG_RESET_JUMP:     cfg_reg.reset_jump     <= cfg_data[LIMIT_W-1:0];
                REG_MAX_JUMP:       cfg_reg.max_jump       <= cfg_data[LIMIT_W-1:0];
                REG_BASE_VALID:     cfg_reg.base_valid     <= cfg_data[0];
                REG_BASE_STAMP:     cfg_reg.base_stamp     <= cfg_data[STAMP_W-1:0];
                default:            ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// File: hdl/ftr_core.sv
`default_nettype none

module ftr_core (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire ftr_pkg::cfg_t  cfg,
    input  wire ftr_pkg::in_item_t item,
    input  wire logic      advance,
    output ftr_pkg::out_item_t result
);
    import ftr_pkg::*;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    logic [STAMP_W-1:0]       prev_time_reg,   prev_time_next;
    logic [PROTO_W-1:0]       prev_proto_reg,  prev_proto_next;
    logic [STAMP_W-1:0]       prev_out_reg,    prev_out_next;
    logic [COUNT_W-1:0]       frame_count_reg, frame_count_next;
    logic signed [DEBT_W-1:0] debt_reg,        debt_next;

    logic [PERIOD_W-1:0]      inc;
    logic signed [DEBT_W-1:0] max_adj;
    logic signed [DEBT_W-1:0] td;
    logic signed [DEBT_W-1:0] td_mag;
    logic signed [DEBT_W-1:0] delta;
    logic signed [DEBT_W:0]   sum_retreat;
    logic signed [DEBT_W:0]   sum_normal;
    logic [STAMP_W:0]         next_medium;
    logic                     first, repeat_proto, td_neg, retreat_ok;
    logic                     gap_medium, gap_big, fault;
    logic [STAMP_W-1:0]       stamp_pre, stamp_new;
    logic signed [DEBT_W-1:0] debt_pre, adj;

    // Saturate a one-bit-wider sum to the debt range.
    function automatic logic signed [DEBT_W-1:0] clamp_debt(input logic signed [DEBT_W:0] s);
        logic signed [DEBT_W-1:0] r;
        if (s[DEBT_W] != s[DEBT_W-1])
            r = s[DEBT_W] ? {1'b1, {(DEBT_W-1){1'b0}}} : {1'b0, {(DEBT_W-1){1'b1}}};
        else
            r = s[DEBT_W-1:0];
        return r;
    endfunction

    assign inc     = (frame_count_reg > cfg.warmup_frames) ? item.estimated_period
                                                           : cfg.default_period;
    assign max_adj = $signed({{(DEBT_W-PERIOD_W+1){1'b0}}, inc[PERIOD_W-1:1]});
    assign td      = $signed({1'b0, item.wall_time}) - $signed({1'b0, prev_time_reg});
    assign td_mag  = -td;
    assign delta   = $signed({1'b0, item.wall_time}) - $signed({1'b0, cfg.base_stamp});

    assign first        = (frame_count_reg == '0);
    assign repeat_proto = (item.proto_stamp == prev_proto_reg);
    assign td_neg       = td[DEBT_W-1];
    assign retreat_ok   = td_mag < $signed({{(DEBT_W-LIMIT_W){1'b0}}, cfg.max_retreat});
    assign gap_medium   = !td_neg && (td > $signed({{(DEBT_W-LIMIT_W){1'b0}}, cfg.reset_jump}));
    assign gap_big      = gap_medium && (td > $signed({{(DEBT_W-LIMIT_W){1'b0}}, cfg.max_jump}));
    assign fault        = !first && !repeat_proto && ((td_neg && !retreat_ok) || gap_big);

    assign sum_retreat = $signed({debt_reg[DEBT_W-1], debt_reg}) + $signed({td[DEBT_W-1], td});
    assign sum_normal  = $signed({debt_reg[DEBT_W-1], debt_reg})
                       + $signed({{(DEBT_W-PERIOD_W+1){1'b0}}, inc})
                       - $signed({td[DEBT_W-1], td});
    assign next_medium = {1'b0, prev_out_reg} + {{(STAMP_W-PERIOD_W+1){1'b0}}, cfg.default_period};

    // Stamp and debt before repayment.
    always_comb
    begin
        stamp_pre = prev_out_reg + {{(STAMP_W-PERIOD_W){1'b0}}, inc};
        debt_pre  = debt_reg;
        if (first)
        begin
            stamp_pre = item.wall_time;
            debt_pre  = '0;
            if (cfg.base_valid)
            begin
                if (delta < 0)
                begin
                    stamp_pre = cfg.base_stamp
                              + {{(STAMP_W-PERIOD_W){1'b0}}, cfg.default_period};
                    debt_pre  = delta;
                end
                else if (delta > $signed({{(DEBT_W-PERIOD_W){1'b0}}, cfg.default_period}))
                begin
                    debt_pre = delta - $signed({{(DEBT_W-PERIOD_W){1'b0}}, cfg.default_period});
                end
            end
        end
        else if (repeat_proto)
        begin
            stamp_pre = prev_out_reg;
        end
        else if (td_neg)
        begin
            debt_pre = clamp_debt(sum_retreat);
        end
        else if (gap_medium)
        begin
            stamp_pre = ({1'b0, item.wall_time} > next_medium) ? item.wall_time
                                                               : next_medium[STAMP_W-1:0];
            debt_pre  = '0;
        end
        else
        begin
            debt_pre = clamp_debt(sum_normal);
        end
    end

    // Repay at most half a period of debt on every new frame.
    always_comb
    begin
        adj = '0;
        if (first || !repeat_proto)
        begin
            if (debt_pre > 0)
                adj = (debt_pre < max_adj) ? debt_pre : max_adj;
            else
                adj = (debt_pre > -max_adj) ? debt_pre : -max_adj;
        end
        stamp_new = stamp_pre - adj[STAMP_W-1:0];
    end

    always_comb
    begin
        prev_time_next   = item.wall_time;
        prev_proto_next  = item.proto_stamp;
        prev_out_next    = stamp_new;
        debt_next        = debt_pre - adj;
        frame_count_next = (frame_count_reg == COUNT_MAX) ? COUNT_MAX : frame_count_reg + 1'b1;
        if (!first && !repeat_proto && !td_neg && gap_medium)
            frame_count_next = COUNT_W'(1);
        if (fault)
        begin
            prev_time_next   = '0;
            prev_proto_next  = '0;
            prev_out_next    = '0;
            debt_next        = '0;
            frame_count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_time_reg   <= '0;
            prev_proto_reg  <= '0;
            prev_out_reg    <= '0;
            frame_count_reg <= '0;
            debt_reg        <= '0;
        end
        else if (advance)
        begin
            prev_time_reg   <= prev_time_next;
            prev_proto_reg  <= prev_proto_next;
            prev_out_reg    <= prev_out_next;
            frame_count_reg <= frame_count_next;
            debt_reg        <= debt_next;
        end
    end

    assign result.out_stamp = fault ? '0 : stamp_new;
    assign result.error     = fault;

endmodule

`default_nettype wire

// File: hdl/frame_timestamp_regenerator_top.sv
// An accepted beat is held in the input register and moves into the result
// register once that register is empty or is being drained.
// Throughput: one beat per cycle while result_ready stays high; the per-beat
// timing loop through the core's state registers closes through combinational logic alone.
// Reset: rst_n is asynchronous and active low; it empties both stages, clears
// the timing state and loads the configuration registers with their defaults.
`default_nettype none

module frame_timestamp_regenerator_top (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           item_valid,
    output wire logic                           item_ready,
    input  wire ftr_pkg::in_item_t              item,
    output wire logic                           result_valid,
    input  wire logic                           result_ready,
    output ftr_pkg::out_item_t                  result,
    input  wire logic                           cfg_we,
    input  wire logic [ftr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ftr_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ftr_pkg::*;

    cfg_t      cfg;
    in_item_t  item_reg;
    logic      item_valid_reg;
    out_item_t core_result;
    out_item_t result_reg;
    logic      result_valid_reg;
    logic      advance;

    // The held input beat moves on when the result register is empty or is
    // being drained in this cycle. The input register refills in the same
    // cycle, so a new beat can be taken every clock while the result register drains.
    assign advance    = item_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready = !item_valid_reg || advance;

    ftr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // The core holds the timing state and works out the result of the held
    // beat; its state registers update only when that beat moves on.
    ftr_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .item    (item_reg),
        .advance (advance),
        .result  (core_result)
    );

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            item_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg <= item;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= core_result;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

// File: bench/testbench.sv
`timescale 1ns / 100ps

// Self-checking bench for the frame timestamp regenerator.
//
// Input beats come from a queue that the main initial block fills. A clocked
// driver presents them on the falling edge. Every accepted beat is run
// through a timestamp model kept in this file, and its expected result is
// queued. A clocked monitor compares each result beat, field by field, with
// the oldest queued expectation. Configuration is written only while nothing
// is in flight: right after reset and between phases.
module testbench;
    import ftr_pkg::*;

    localparam int     LIMIT_CYCLES = 200000;
    localparam int     COUNT_SAT    = 1023;
    localparam longint DEBT_HI      = 64'sh0000_FFFF_FFFF_FFFF;
    localparam longint DEBT_LO      = -DEBT_HI - 1;
    localparam longint STAMP_MASK   = 64'sh0000_FFFF_FFFF_FFFF;
    // Index past the last register; the block must ignore a write to it.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_ready;
    in_item_t item = '0;
    logic result_valid;
    logic result_ready = 1'b0;
    out_item_t result;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    frame_timestamp_regenerator_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Beats waiting to be driven, and the timestamps we expect back, in order.
    in_item_t  frames_to_send[$];
    out_item_t pending_stamps[$];
    out_item_t next_result;

    // Idle rates, in percent, for the sender and the receiver.
    int send_idle_pct = 37;
    int recv_idle_pct = 47;

    logic item_taken = 1'b0;
    int cycle_count = 0;
    int mismatches = 0;
    int beats_checked = 0;
    int fault_beats = 0;
    int settings_used = 0;

    // Our copy of the configuration registers, starting from the reset values.
    cfg_t cfg_shadow = '{
        default_period: DEFAULT_PERIOD_RST,
        warmup_frames:  WARMUP_FRAMES_RST,
        max_retreat:    MAX_RETREAT_RST,
        reset_jump:     RESET_JUMP_RST,
        max_jump:       MAX_JUMP_RST,
        base_valid:     1'b0,
        base_stamp:     '0
    };

    // Timing state of the model. The debt is a signed 49-bit quantity that is
    // carried in a longint and saturated by hand.
    longint            prev_wall = 0;
    logic [PROTO_W-1:0] prev_proto = '0;
    longint            prev_out = 0;
    int                frame_count = 0;
    longint            debt = 0;

    // State of the random stream generator.
    longint gen_wall;
    longint gen_proto;
    longint gen_period;

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic longint clamp_debt(longint v);
        if (v > DEBT_HI) return DEBT_HI;
        if (v < DEBT_LO) return DEBT_LO;
        return v;
    endfunction

    // Works out the timestamp for one accepted frame and advances the model.
    function automatic out_item_t regenerate_stamp(in_item_t frame);
        longint wall, inc, dflt, half, gap, delta, stamp, adj;
        bit fresh, fault;
        out_item_t res;
        wall  = longint'(frame.wall_time);
        dflt  = longint'(cfg_shadow.default_period);
        // The external period estimate is trusted only after the warmup.
        inc   = (frame_count > int'(cfg_shadow.warmup_frames))
                ? longint'(frame.estimated_period) : dflt;
        half  = inc / 2;
        gap   = wall - prev_wall;
        stamp = 0;
        fresh = 1'b1;
        fault = 1'b0;
        res   = '0;

        if (frame_count == 0) begin
            // First frame: take the wall clock, or continue the base stamp and
            // carry the difference as debt.
            stamp = wall;
            debt  = 0;
            if (cfg_shadow.base_valid) begin
                delta = wall - longint'(cfg_shadow.base_stamp);
                if (delta < 0) begin
                    stamp = longint'(cfg_shadow.base_stamp) + dflt;
                    debt  = delta;
                end else if (delta > dflt) begin
                    debt = delta - dflt;
                end
            end
        end else if (frame.proto_stamp == prev_proto) begin
            // Same protocol stamp as before: repeat the previous output.
            stamp = prev_out;
            fresh = 1'b0;
        end else if (gap < 0) begin
            if (-gap < longint'(cfg_shadow.max_retreat)) begin
                stamp = prev_out + inc;
                debt  = clamp_debt(debt + gap);
            end else begin
                fault = 1'b1;
            end
        end else if (gap > longint'(cfg_shadow.reset_jump)) begin
            if (gap > longint'(cfg_shadow.max_jump)) begin
                fault = 1'b1;
            end else begin
                // Medium gap: restart from the wall clock, never going back.
                stamp       = (wall > prev_out + dflt) ? wall : prev_out + dflt;
                frame_count = 0;
                debt        = 0;
            end
        end else begin
            stamp = prev_out + inc;
            debt  = clamp_debt(debt + inc - gap);
        end

        if (fault) begin
            prev_wall   = 0;
            prev_proto  = '0;
            prev_out    = 0;
            frame_count = 0;
            debt        = 0;
            res.error   = 1'b1;
        end else begin
            if (fresh) begin
                // Repay the debt by at most half a period per new frame.
                if (debt > 0)
                    adj = (debt < half) ? debt : half;
                else
                    adj = (debt > -half) ? debt : -half;
                debt  = debt - adj;
                stamp = stamp - adj;
            end
            res.out_stamp = stamp[STAMP_W-1:0];
            prev_wall     = wall;
            prev_proto    = frame.proto_stamp;
            prev_out      = longint'(res.out_stamp);
            if (frame_count < COUNT_SAT)
                frame_count++;
        end
        return res;
    endfunction

    // Driver: a new beat goes out only when the line is free or the current
    // beat was taken at the last rising edge, so valid never drops early.
    always @(negedge clk) begin
        if (rst_n) begin
            if (!item_valid || item_taken) begin
                if (frames_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    item       <= frames_to_send.pop_front();
                    item_valid <= 1'b1;
                end else begin
                    item_valid <= 1'b0;
                end
            end
            result_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Monitor: check any result beat first, then record the expectation of
    // an input beat accepted at the same edge. A beat passes the input and then the
    // result register, so a result can never belong to the beat taken at the same edge.
    always @(posedge clk) begin
        if (rst_n) begin
            if (result_valid && result_ready) begin
                if (pending_stamps.size() == 0) begin
                    $display("%0t: unexpected result beat stamp=%0d error=%0b",
                             $time, result.out_stamp, result.error);
                    mismatches++;
                end else begin
                    next_result = pending_stamps.pop_front();
                    if (result.out_stamp !== next_result.out_stamp) begin
                        $display("%0t: out_stamp expected %0d, got %0d",
                                 $time, next_result.out_stamp, result.out_stamp);
                        mismatches++;
                    end
                    if (result.error !== next_result.error) begin
                        $display("%0t: error expected %0b, got %0b",
                                 $time, next_result.error, result.error);
                        mismatches++;
                    end
                    beats_checked++;
                    if (next_result.error)
                        fault_beats++;
                end
            end
            if (item_valid && item_ready)
                pending_stamps.push_back(regenerate_stamp(item));
        end
        item_taken <= rst_n && item_valid && item_ready;
    end

    // Watchdog against a stalled handshake.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, pending_stamps.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic push_frame(logic [PROTO_W-1:0] proto, logic [STAMP_W-1:0] wall,
                              logic [PERIOD_W-1:0] est);
        in_item_t f;
        f.proto_stamp      = proto;
        f.wall_time        = wall;
        f.estimated_period = est;
        frames_to_send.push_back(f);
    endtask

    // Waits until nothing is queued, driven or expected. The check is made a
    // little after each falling edge, once the driver's updates have settled.
    task automatic drain();
        while (frames_to_send.size() != 0 || item_valid || pending_stamps.size() != 0)
        begin
            @(negedge clk);
            #1;
        end
    endtask

    // Raises the write enable with one register's index and data; the caller
    // lowers it once the last register of a group is written.
    task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_DEFAULT_PERIOD: cfg_shadow.default_period = val[PERIOD_W-1:0];
            REG_WARMUP_FRAMES:  cfg_shadow.warmup_frames  = val[COUNT_W-1:0];
            REG_MAX_RETREAT:    cfg_shadow.max_retreat    = val[LIMIT_W-1:0];
            REG_RESET_JUMP:     cfg_shadow.reset_jump     = val[LIMIT_W-1:0];
            REG_MAX_JUMP:       cfg_shadow.max_jump       = val[LIMIT_W-1:0];
            REG_BASE_VALID:     cfg_shadow.base_valid     = val[0];
            REG_BASE_STAMP:     cfg_shadow.base_stamp     = val[STAMP_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(int dp, int wu, int mr, int rj, int mj, bit bv,
                                  logic [STAMP_W-1:0] bs);
        set_reg(REG_DEFAULT_PERIOD, CFG_DATA_W'(dp));
        set_reg(REG_WARMUP_FRAMES, CFG_DATA_W'(wu));
        set_reg(REG_MAX_RETREAT, CFG_DATA_W'(mr));
        set_reg(REG_RESET_JUMP, CFG_DATA_W'(rj));
        set_reg(REG_MAX_JUMP, CFG_DATA_W'(mj));
        set_reg(REG_BASE_VALID, CFG_DATA_W'(bv));
        set_reg(REG_BASE_STAMP, CFG_DATA_W'(bs));
        @(negedge clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Starts a new stream somewhere in the 48-bit range.
    task automatic start_stream(longint period);
        gen_wall   = longint'($urandom_range(0, 32'h7fff_ffff)) << $urandom_range(0, 16);
        gen_proto  = {$urandom, $urandom};
        gen_period = period;
    endtask

    // Mostly a well-behaved stream with jitter, mixed with repeats, retreats,
    // gaps of every size, exact threshold steps and plain noise.
    task automatic queue_random_frames(int count);
        int pick;
        longint step, est;
        longint mr, rj, mj;
        mr = longint'(cfg_shadow.max_retreat);
        rj = longint'(cfg_shadow.reset_jump);
        mj = longint'(cfg_shadow.max_jump);
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                step = gen_period - 3 + $urandom_range(0, 6);
            end else if (pick < 70) begin
                step = $urandom_range(0, 50);
            end else if (pick < 78) begin
                step = -longint'($urandom_range(1, (mr > 1) ? mr : 1));
            end else if (pick < 86) begin
                step = rj + $urandom_range(1, (mj > rj) ? mj - rj : 1);
            end else if (pick < 90) begin
                step = ((mj > rj) ? mj : rj) + $urandom_range(1, 2000);
            end else if (pick < 94) begin
                step = -(mr + $urandom_range(0, 1000));
            end else if (pick < 97) begin
                case ($urandom_range(0, 3))
                    0: step = rj;
                    1: step = mj;
                    2: step = -mr;
                    default: step = -(mr - 1);
                endcase
            end else begin
                step = 0;
            end

            if (pick >= 97) begin
                gen_wall  = {$urandom, $urandom} & STAMP_MASK;
                gen_proto = {$urandom, $urandom};
            end else begin
                gen_wall = gen_wall + step;
                if (gen_wall < 0)
                    gen_wall = 0;
                gen_wall = gen_wall & STAMP_MASK;
                // Repeats keep the protocol stamp; everything else moves it on.
                if (pick >= 70 || pick < 60)
                    gen_proto = gen_proto + 1;
            end

            if ($urandom_range(0, 4) != 0) begin
                est = gen_period - 2 + $urandom_range(0, 4);
                if (est < 0)
                    est = 0;
                if (est > 1023)
                    est = 1023;
            end else begin
                est = $urandom_range(0, 1023);
            end
            push_frame(gen_proto, gen_wall[STAMP_W-1:0], est[PERIOD_W-1:0]);
        end
    endtask

    initial begin
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed frames under the reset settings. Each group ends in a
        // clock fault, so the next group starts from a first frame.
        push_frame(64'd1, 48'd1000, 10'd0);          // first frame takes the wall clock
        push_frame(64'd1, 48'd1040, 10'd1023);       // repeated protocol stamp
        push_frame(64'd2, 48'd1040, 10'd40);         // normal step
        push_frame(64'd3, 48'd1000, 10'd40);         // small retreat
        push_frame(64'd4, 48'd900, 10'd40);          // retreat of exactly max_retreat
        push_frame(64'd0, 48'd0, 10'd40);            // first frame, proto equal to reset
        push_frame(64'd5, 48'd1000, 10'd40);         // gap of exactly reset_jump
        push_frame(64'd6, 48'd2001, 10'd40);         // medium gap
        push_frame(64'd7, 48'd7002, 10'd40);         // large gap after the restart
        push_frame(64'h8000_0000_0000_0000, 48'hFFFF_FFFF_FFFF, 10'd0);
        push_frame(64'h7FFF_FFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 10'd1023); // stamp wraps
        push_frame(64'hFFFF_FFFF_FFFF_FFFF, 48'hFFFF_FFFF_FF9C, 10'd1);
        push_frame(64'hFFFF_FFFF_FFFF_FFFE, 48'd0, 10'd1); // huge retreat
        drain();

        // Continuing a base stamp far behind the wall clock: the positive
        // debt grows with a period of one until it saturates.
        apply_settings(1, 200, 100, 1000, 5000, 1'b1, 48'd0);
        push_frame(64'd10, 48'hFFFF_FFFF_FFFF, 10'd2);
        push_frame(64'd11, 48'hFFFF_FFFF_FFFF, 10'd2);
        push_frame(64'd12, 48'hFFFF_FFFF_FFFF, 10'd2);
        push_frame(64'd13, 48'd0, 10'd2);
        drain();

        // Base stamp far ahead of the wall clock: negative debt saturates.
        apply_settings(1, 200, 100, 1000, 5000, 1'b1, 48'hFFFF_FFFF_FFFF);
        push_frame(64'd20, 48'd99, 10'd2);
        push_frame(64'd21, 48'd0, 10'd2);
        push_frame(64'd22, 48'd2, 10'd2);
        push_frame(64'd23, 48'd4, 10'd2);
        push_frame(64'd24, 48'd4, 10'd2);
        push_frame(64'd25, 48'd1000000, 10'd2);
        drain();

        // Reset settings again, with a random stream.
        start_stream(40);
        apply_settings(40, 200, 100, 1000, 5000, 1'b0, 48'd0);
        queue_random_frames(150);
        drain();

        // The other idle pattern. Here max_jump lies below reset_jump, so a gap
        // between the two takes the normal path.
        send_idle_pct = 47;
        recv_idle_pct = 37;
        start_stream(33);
        apply_settings(33, 3, 500, 2000, 1500, 1'b1,
                       STAMP_W'(gen_wall + $urandom_range(0, 400) - 200));
        queue_random_frames(150);
        drain();

        // Every register but base_valid at its top value, plus a write the block must ignore.
        start_stream(1023);
        set_reg(REG_UNUSED, '1);
        apply_settings(1023, 1023, 65535, 65535, 65535, 1'b0, 48'hFFFF_FFFF_FFFF);
        queue_random_frames(120);
        drain();

        // No idling from here on. Bottom values first: zero period, no warmup,
        // and thresholds that turn almost every step into a fault.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        start_stream(0);
        apply_settings(0, 0, 0, 0, 0, 1'b1, STAMP_W'(gen_wall));
        queue_random_frames(40);
        drain();

        start_stream($urandom_range(1, 1000));
        apply_settings(int'(gen_period), $urandom_range(0, 30), $urandom_range(1, 300),
                       $urandom_range(200, 3000), $urandom_range(200, 8000),
                       1'(($urandom_range(0, 1))), STAMP_W'(gen_wall - 300));
        queue_random_frames(150);
        drain();

        // The estimate is trusted from the second frame on; the base stamp
        // lags the wall clock, so positive debt is repaid over many frames.
        start_stream(40);
        apply_settings(40, 0, 100, 1000, 5000, 1'b1, STAMP_W'(gen_wall - 500));
        queue_random_frames(140);
        drain();

        repeat (10) @(negedge clk);
        $display("Checked %0d result beats, %0d of them clock faults, under %0d settings",
                 beats_checked, fault_beats, settings_used);
        $display("and three idle patterns, in %0d cycles; %0d mismatches.",
                 cycle_count, mismatches);
        if (mismatches == 0 && pending_stamps.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule

// File: frame_timestamp_regenerator_top.f
hdl/ftr_pkg.sv
hdl/ftr_cfg.sv
hdl/ftr_core.sv
hdl/frame_timestamp_regenerator_top.sv
bench/testbench.sv
